@@ design/cpvpi_pkg.sv @@
// cpvpi_pkg: shared types, register map, mode codes and reset values for the
// cascaded position/velocity pi controller; no dependencies
`default_nettype none

package cpvpi_pkg;

    // fixed field widths
    localparam int MODE_W     = 2;
    localparam int GAIN_W     = 16;
    localparam int GAIN_FRAC  = 12;
    localparam int GRAV_W     = 21;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int DIGIT_W    = 4;
    localparam int AXES       = 3;

    // mode codes of an input item
    localparam logic [MODE_W-1:0] MODE_RESET = 2'd0;
    localparam logic [MODE_W-1:0] MODE_HOLD  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FF    = 2'd2;

    // axis index of z
    localparam logic [1:0] AXIS_Z = 2'd2;

    // register map
    localparam logic [CFG_IDX_W-1:0] REG_POS_GAIN_H = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POS_GAIN_V = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VEL_KP_H   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VEL_KI_H   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VEL_KP_V   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_VEL_KI_V   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_GRAVITY    = 3'd6;

    // register reset values
    localparam logic [GAIN_W-1:0] RST_POS_GAIN_H = 16'd3686;
    localparam logic [GAIN_W-1:0] RST_POS_GAIN_V = 16'd4096;
    localparam logic [GAIN_W-1:0] RST_VEL_KP_H   = 16'd8192;
    localparam logic [GAIN_W-1:0] RST_VEL_KI_H   = 16'd1638;
    localparam logic [GAIN_W-1:0] RST_VEL_KP_V   = 16'd16384;
    localparam logic [GAIN_W-1:0] RST_VEL_KI_V   = 16'd8192;
    localparam logic [GRAV_W-1:0] RST_GRAVITY    = 21'd642908;

    typedef struct packed {
        logic [GAIN_W-1:0] pos_gain_h;
        logic [GAIN_W-1:0] pos_gain_v;
        logic [GAIN_W-1:0] vel_kp_h;
        logic [GAIN_W-1:0] vel_ki_h;
        logic [GAIN_W-1:0] vel_kp_v;
        logic [GAIN_W-1:0] vel_ki_v;
        logic [GRAV_W-1:0] gravity;
    } t_cfg;

    // top level to loop sequencer
    typedef struct packed {
        logic run;
        logic clear;
    } t_loop_ctl;

    // loop sequencer to top level
    typedef struct packed {
        logic busy;
        logic done;
    } t_loop_sts;

    typedef enum logic [1:0] {
        TS_IDLE,
        TS_LOOP,
        TS_FORM
    } t_top_state;

    typedef enum logic [3:0] {
        LS_IDLE,
        LS_POS_GO,
        LS_POS_WAIT,
        LS_INT_GO,
        LS_INT_WAIT,
        LS_KP_GO,
        LS_KP_WAIT,
        LS_KI_GO,
        LS_KI_WAIT,
        LS_OUT
    } t_loop_state;

endpackage

`default_nettype wire

@@ design/cpvpi_cfg.sv @@
// cpvpi_cfg: configuration register file for gains and gravity
// depends on cpvpi_pkg
`default_nettype none

module cpvpi_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [cpvpi_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [cpvpi_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output cpvpi_pkg::t_cfg                  o_cfg
);
    import cpvpi_pkg::*;

    t_cfg r_cfg;
    logic w_wr;

    // writes are taken in any cycle
    assign o_cfg_ready = 1'b1;
    assign w_wr        = i_cfg_valid && o_cfg_ready;
    assign o_cfg       = r_cfg;

    // register write, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pos_gain_h <= RST_POS_GAIN_H;
            r_cfg.pos_gain_v <= RST_POS_GAIN_V;
            r_cfg.vel_kp_h   <= RST_VEL_KP_H;
            r_cfg.vel_ki_h   <= RST_VEL_KI_H;
            r_cfg.vel_kp_v   <= RST_VEL_KP_V;
            r_cfg.vel_ki_v   <= RST_VEL_KI_V;
            r_cfg.gravity    <= RST_GRAVITY;
        end else if (w_wr) begin
            case (i_cfg_index)
                REG_POS_GAIN_H: r_cfg.pos_gain_h <= i_cfg_data[GAIN_W-1:0];
                REG_POS_GAIN_V: r_cfg.pos_gain_v <= i_cfg_data[GAIN_W-1:0];
                REG_VEL_KP_H:   r_cfg.vel_kp_h   <= i_cfg_data[GAIN_W-1:0];
                REG_VEL_KI_H:   r_cfg.vel_ki_h   <= i_cfg_data[GAIN_W-1:0];
                REG_VEL_KP_V:   r_cfg.vel_kp_v   <= i_cfg_data[GAIN_W-1:0];
                REG_VEL_KI_V:   r_cfg.vel_ki_v   <= i_cfg_data[GAIN_W-1:0];
                REG_GRAVITY:    r_cfg.gravity    <= i_cfg_data[GRAV_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ design/cpvpi_mul.sv @@
// cpvpi_mul: digit-serial multiplier, signed multiplicand by unsigned multiplier,
// one 4-bit digit of the multiplier per cycle, most significant digit first
// depends on cpvpi_pkg
`default_nettype none

module cpvpi_mul #(
    parameter int A_W = 32,
    parameter int M_W = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic signed [A_W-1:0]  i_a,
    input  logic [M_W-1:0]         i_m,
    output logic                   o_done,
    output logic signed [A_W+M_W:0] o_prod
);
    import cpvpi_pkg::*;

    localparam int P_W   = A_W + M_W + 1;
    localparam int N_DIG = M_W / DIGIT_W;
    localparam int CNT_W = (N_DIG > 1) ? $clog2(N_DIG) : 1;
    localparam logic [CNT_W-1:0] LAST = CNT_W'(N_DIG - 1);

    logic                      r_busy;
    logic                      r_done;
    logic [CNT_W-1:0]          r_cnt;
    logic signed [A_W-1:0]     r_a;
    logic [M_W-1:0]            r_m;
    logic signed [P_W-1:0]     r_acc;
    logic [DIGIT_W-1:0]        w_digit;
    logic signed [A_W+DIGIT_W:0] w_pp;

    // partial product of the current digit
    assign w_digit = r_m[M_W-1 -: DIGIT_W];
    assign w_pp    = r_a * $signed({1'b0, w_digit});
    assign o_done  = r_done;
    assign o_prod  = r_acc;

    // digit counter and done flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // shift and accumulate
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_m   <= i_m;
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= (r_acc <<< DIGIT_W) + P_W'(w_pp);
            r_m   <= r_m << DIGIT_W;
        end
    end

`ifndef SYNTHESIS
    // a new product never starts over one in progress
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("multiplier started while busy");
`endif

endmodule

`default_nettype wire

@@ design/cpvpi_loop.sv @@
// cpvpi_loop: per-axis sequencer of the position and velocity pi loops, owns the
// integrators and the held command; depends on cpvpi_pkg and cpvpi_mul
`default_nettype none

module cpvpi_loop #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cpvpi_pkg::t_cfg               i_cfg,
    input  cpvpi_pkg::t_loop_ctl          i_ctl,
    output cpvpi_pkg::t_loop_sts          o_sts,
    input  logic signed [DATA_WIDTH-1:0]  i_tgt  [3],
    input  logic signed [DATA_WIDTH-1:0]  i_pos  [3],
    input  logic signed [DATA_WIDTH-1:0]  i_vel  [3],
    output logic signed [DATA_WIDTH-1:0]  o_held [3]
);
    import cpvpi_pkg::*;

    localparam int DW     = DATA_WIDTH;
    localparam int F      = FRAC_BITS;
    localparam int DT_Q   = ((1 << F) * 2 + 50) / 100;
    localparam int DT_W   = $clog2(DT_Q + 1);
    localparam int M_RAW  = (DT_W > GAIN_W) ? DT_W : GAIN_W;
    localparam int M_W    = ((M_RAW + DIGIT_W - 1) / DIGIT_W) * DIGIT_W;
    localparam int A_W    = (DW > F + 2) ? DW : F + 2;
    localparam int P_W    = A_W + M_W + 1;
    localparam int PS_W   = P_W + 1;
    localparam int IN_W   = F + 2;
    localparam int VL_W   = (F + 9 > DW) ? F + 9 : DW;

    localparam logic [M_W-1:0]          DT_M     = M_W'(DT_Q);
    localparam logic signed [DW-1:0]    D_MAX    = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0]    D_MIN    = {1'b1, {(DW-1){1'b0}}};
    localparam logic signed [VL_W-1:0]  VI_LIM   = VL_W'(1) << (F + 7);
    localparam logic signed [P_W-1:0]   IN_LIM_P = P_W'(1) << F;
    localparam logic signed [IN_W-1:0]  INT_ONE  = IN_W'(1) << F;
    localparam logic signed [PS_W-1:0]  U_LIM    = PS_W'(1) << (F + 1);
    localparam logic signed [P_W-1:0]   HALF_F   = P_W'(1) << (F - 1);
    localparam logic signed [P_W-1:0]   HALF_G   = P_W'(1) << (GAIN_FRAC - 1);
    localparam logic signed [PS_W-1:0]  HALF_GS  = PS_W'(1) << (GAIN_FRAC - 1);

    t_loop_state r_state, n_state;
    logic [1:0]  r_axis, n_axis;

    logic signed [IN_W-1:0] r_integ [3];
    logic signed [DW-1:0]   r_held  [3];
    logic signed [DW-1:0]   r_verr;
    logic signed [IN_W-1:0] r_in;
    logic signed [P_W-1:0]  r_psum;
    logic signed [PS_W-1:0] r_usum;

    logic                   w_start;
    logic                   w_mul_done;
    logic signed [P_W-1:0]  w_prod;
    logic signed [A_W-1:0]  w_mul_a;
    logic [M_W-1:0]         w_mul_m;
    logic                   w_hz;

    logic signed [DW-1:0]   w_tgt, w_pos, w_vel;
    logic signed [DW:0]     w_perr_x;
    logic signed [DW-1:0]   w_perr;
    logic signed [P_W-1:0]  w_vdes_r;
    logic signed [DW-1:0]   w_vdes;
    logic signed [DW:0]     w_verr_x;
    logic signed [DW-1:0]   w_verr;
    logic signed [VL_W-1:0] w_vl;
    logic signed [VL_W-1:0] w_vi_l;
    logic signed [DW-1:0]   w_vi;
    logic signed [P_W-1:0]  w_di;
    logic signed [P_W-1:0]  w_in_sum;
    logic signed [IN_W-1:0] w_in_new;
    logic signed [PS_W-1:0] w_u_r;
    logic signed [PS_W-1:0] w_u_c;
    logic signed [DW-1:0]   w_u;

    // shared multiplier
    cpvpi_mul #(
        .A_W (A_W),
        .M_W (M_W)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_a     (w_mul_a),
        .i_m     (w_mul_m),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    // operands of the axis in work
    assign w_hz  = (r_axis == AXIS_Z);
    assign w_tgt = i_tgt[r_axis];
    assign w_pos = i_pos[r_axis];
    assign w_vel = i_vel[r_axis];

    // position error, saturated
    assign w_perr_x = (DW+1)'(w_tgt) - (DW+1)'(w_pos);
    assign w_perr   = (w_perr_x[DW] == w_perr_x[DW-1]) ? w_perr_x[DW-1:0] :
                      (w_perr_x[DW] ? D_MIN : D_MAX);

    // desired velocity from the gain product, rounded and saturated
    assign w_vdes_r = (w_prod + HALF_G) >>> GAIN_FRAC;
    assign w_vdes   = ((&w_vdes_r[P_W-1:DW-1]) || !(|w_vdes_r[P_W-1:DW-1])) ?
                      w_vdes_r[DW-1:0] : (w_vdes_r[P_W-1] ? D_MIN : D_MAX);

    // velocity error, saturated
    assign w_verr_x = (DW+1)'(w_vdes) - (DW+1)'(w_vel);
    assign w_verr   = (w_verr_x[DW] == w_verr_x[DW-1]) ? w_verr_x[DW-1:0] :
                      (w_verr_x[DW] ? D_MIN : D_MAX);

    // integrator input limited to +-128
    assign w_vl   = VL_W'(r_verr);
    assign w_vi_l = (w_vl > VI_LIM) ? VI_LIM : ((w_vl < -VI_LIM) ? -VI_LIM : w_vl);
    assign w_vi   = DW'(w_vi_l);

    // integrator update, clamped to +-1
    assign w_di     = (w_prod + HALF_F) >>> F;
    assign w_in_sum = P_W'(r_integ[r_axis]) + w_di;
    assign w_in_new = (w_in_sum > IN_LIM_P) ? INT_ONE :
                      ((w_in_sum < -IN_LIM_P) ? -INT_ONE : IN_W'(w_in_sum));

    // pi output, rounded, clamped to +-2 and fitted to the data width
    assign w_u_r = (r_usum + HALF_GS) >>> GAIN_FRAC;
    assign w_u_c = (w_u_r > U_LIM) ? U_LIM : ((w_u_r < -U_LIM) ? -U_LIM : w_u_r);
    assign w_u   = ((&w_u_c[PS_W-1:DW-1]) || !(|w_u_c[PS_W-1:DW-1])) ?
                   w_u_c[DW-1:0] : (w_u_c[PS_W-1] ? D_MIN : D_MAX);

    // multiplier operand selection
    always_comb begin
        case (r_state)
            LS_POS_GO: begin
                w_mul_a = A_W'(w_perr);
                w_mul_m = M_W'(w_hz ? i_cfg.pos_gain_v : i_cfg.pos_gain_h);
            end
            LS_INT_GO: begin
                w_mul_a = A_W'(w_vi);
                w_mul_m = DT_M;
            end
            LS_KP_GO: begin
                w_mul_a = A_W'(r_verr);
                w_mul_m = M_W'(w_hz ? i_cfg.vel_kp_v : i_cfg.vel_kp_h);
            end
            default: begin
                w_mul_a = A_W'(r_in);
                w_mul_m = M_W'(w_hz ? i_cfg.vel_ki_v : i_cfg.vel_ki_h);
            end
        endcase
    end

    // sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= LS_IDLE;
            r_axis  <= '0;
        end else begin
            r_state <= n_state;
            r_axis  <= n_axis;
        end
    end

    // sequencer next state and outputs
    always_comb begin
        n_state    = r_state;
        n_axis     = r_axis;
        w_start    = 1'b0;
        o_sts.busy = (r_state != LS_IDLE);
        o_sts.done = 1'b0;
        case (r_state)
            LS_IDLE: begin
                if (i_ctl.run) begin
                    n_axis  = '0;
                    n_state = LS_POS_GO;
                end
            end
            LS_POS_GO: begin
                w_start = 1'b1;
                n_state = LS_POS_WAIT;
            end
            LS_POS_WAIT: if (w_mul_done) n_state = LS_INT_GO;
            LS_INT_GO: begin
                w_start = 1'b1;
                n_state = LS_INT_WAIT;
            end
            LS_INT_WAIT: if (w_mul_done) n_state = LS_KP_GO;
            LS_KP_GO: begin
                w_start = 1'b1;
                n_state = LS_KP_WAIT;
            end
            LS_KP_WAIT: if (w_mul_done) n_state = LS_KI_GO;
            LS_KI_GO: begin
                w_start = 1'b1;
                n_state = LS_KI_WAIT;
            end
            LS_KI_WAIT: if (w_mul_done) n_state = LS_OUT;
            LS_OUT: begin
                if (r_axis == AXIS_Z) begin
                    o_sts.done = 1'b1;
                    n_state    = LS_IDLE;
                end else begin
                    n_axis  = r_axis + 2'd1;
                    n_state = LS_POS_GO;
                end
            end
            default: n_state = LS_IDLE;
        endcase
    end

    // integrators and held command
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < AXES; k++) begin
                r_integ[k] <= '0;
                r_held[k]  <= '0;
            end
        end else begin
            if (i_ctl.clear) begin
                for (int k = 0; k < AXES; k++) begin
                    r_integ[k] <= '0;
                end
            end else if (r_state == LS_INT_WAIT && w_mul_done) begin
                r_integ[r_axis] <= w_in_new;
            end
            if (r_state == LS_OUT) begin
                r_held[r_axis] <= w_u;
            end
        end
    end

    // intermediate results of the axis in work
    always_ff @(posedge i_clk) begin
        if (r_state == LS_POS_WAIT && w_mul_done) r_verr <= w_verr;
        if (r_state == LS_INT_WAIT && w_mul_done) r_in <= w_in_new;
        if (r_state == LS_KP_WAIT && w_mul_done) r_psum <= w_prod;
        if (r_state == LS_KI_WAIT && w_mul_done) r_usum <= PS_W'(r_psum) + PS_W'(w_prod);
    end

    assign o_held = r_held;

`ifndef SYNTHESIS
    // a new run only starts from idle
    a_run_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.run |-> r_state == LS_IDLE)
        else $error("loop run requested while busy");

    // integrators stay within +-1
    a_integ_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_integ[0] <= INT_ONE && r_integ[0] >= -INT_ONE &&
        r_integ[1] <= INT_ONE && r_integ[1] >= -INT_ONE &&
        r_integ[2] <= INT_ONE && r_integ[2] >= -INT_ONE)
        else $error("integrator out of range");
`endif

endmodule

`default_nettype wire

@@ design/cascaded_position_velocity_pi_top.sv @@
// cascaded_position_velocity_pi_top: item handshakes, mode handling, gravity and
// output register; depends on cpvpi_pkg, cpvpi_cfg and cpvpi_loop
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+----------------------------------------
//  input    | i_in_valid / o_in_ready    | i_mode, i_target_*, i_meas_pos_*, i_meas_vel_*
//  output   | o_out_valid / i_out_ready  | o_acc_x, o_acc_y, o_acc_z, o_fresh
//  config   | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// an item that needs no loop update passes the forming step into the output register
// a hold item on an even tick runs the loop: one shared digit-serial multiplier
// (four 4-bit digits at 16 fraction bits) does four products per axis, axes in turn
// the next item is taken while the output register still waits to be taken
// a stalled output holds the block in its forming step until the register frees
// synchronous active-low reset; the config port takes a write in every cycle
`default_nettype none

module cascaded_position_velocity_pi_top #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [cpvpi_pkg::MODE_W-1:0]     i_mode,
    input  logic signed [DATA_WIDTH-1:0]     i_target_x,
    input  logic signed [DATA_WIDTH-1:0]     i_target_y,
    input  logic signed [DATA_WIDTH-1:0]     i_target_z,
    input  logic signed [DATA_WIDTH-1:0]     i_meas_pos_x,
    input  logic signed [DATA_WIDTH-1:0]     i_meas_pos_y,
    input  logic signed [DATA_WIDTH-1:0]     i_meas_pos_z,
    input  logic signed [DATA_WIDTH-1:0]     i_meas_vel_x,
    input  logic signed [DATA_WIDTH-1:0]     i_meas_vel_y,
    input  logic signed [DATA_WIDTH-1:0]     i_meas_vel_z,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic signed [DATA_WIDTH-1:0]     o_acc_x,
    output logic signed [DATA_WIDTH-1:0]     o_acc_y,
    output logic signed [DATA_WIDTH-1:0]     o_acc_z,
    output logic                             o_fresh,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [cpvpi_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [cpvpi_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import cpvpi_pkg::*;

    localparam int DW    = DATA_WIDTH;
    localparam int SUM_W = ((DW > GRAV_W) ? DW : GRAV_W) + 2;
    localparam logic signed [DW-1:0] D_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] D_MIN = {1'b1, {(DW-1){1'b0}}};

    t_top_state r_state, n_state;
    t_cfg       w_cfg;
    t_loop_ctl  w_ctl;
    t_loop_sts  w_sts;

    logic                 r_phase;
    logic [MODE_W-1:0]    r_mode;
    logic                 r_fresh;
    logic signed [DW-1:0] r_tgt [3];
    logic signed [DW-1:0] r_pos [3];
    logic signed [DW-1:0] r_vel [3];
    logic signed [DW-1:0] w_held [3];

    logic                 r_out_valid;
    logic signed [DW-1:0] r_acc_x, r_acc_y, r_acc_z;
    logic                 r_out_fresh;

    logic                    w_accept;
    logic                    w_load;
    logic signed [DW-1:0]    w_cmd_x, w_cmd_y, w_cmd_z;
    logic signed [SUM_W-1:0] w_grav;
    logic signed [SUM_W-1:0] w_zsum;
    logic signed [DW-1:0]    w_zsat;
    logic signed [DW-1:0]    w_gsat;
    logic signed [DW-1:0]    w_z_out;

    // configuration registers
    cpvpi_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // cascaded loop over the three axes
    cpvpi_loop #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_loop (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_ctl   (w_ctl),
        .o_sts   (w_sts),
        .i_tgt   (r_tgt),
        .i_pos   (r_pos),
        .i_vel   (r_vel),
        .o_held  (w_held)
    );

    // control state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= TS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state, handshake and loop control
    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        w_accept    = 1'b0;
        w_load      = 1'b0;
        w_ctl.run   = 1'b0;
        w_ctl.clear = 1'b0;
        case (r_state)
            TS_IDLE: begin
                o_in_ready = 1'b1;
                w_accept   = i_in_valid;
                if (w_accept) begin
                    if (i_mode == MODE_HOLD) begin
                        if (!r_phase) begin
                            w_ctl.run = 1'b1;
                            n_state   = TS_LOOP;
                        end else begin
                            n_state = TS_FORM;
                        end
                    end else begin
                        w_ctl.clear = 1'b1;
                        n_state     = TS_FORM;
                    end
                end
            end
            TS_LOOP: if (w_sts.done) n_state = TS_FORM;
            TS_FORM: begin
                w_load = !r_out_valid || i_out_ready;
                if (w_load) n_state = TS_IDLE;
            end
            default: n_state = TS_IDLE;
        endcase
    end

    // tick phase toggles on every item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 1'b0;
        end else if (w_accept) begin
            r_phase <= !r_phase;
        end
    end

    // capture of the input item
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode   <= i_mode;
            r_fresh  <= (i_mode == MODE_HOLD) && !r_phase;
            r_tgt[0] <= i_target_x;
            r_tgt[1] <= i_target_y;
            r_tgt[2] <= i_target_z;
            r_pos[0] <= i_meas_pos_x;
            r_pos[1] <= i_meas_pos_y;
            r_pos[2] <= i_meas_pos_z;
            r_vel[0] <= i_meas_vel_x;
            r_vel[1] <= i_meas_vel_y;
            r_vel[2] <= i_meas_vel_z;
        end
    end

    // command by mode; undefined mode behaves as feedforward
    always_comb begin
        case (r_mode)
            MODE_RESET: begin
                w_cmd_x = '0;
                w_cmd_y = '0;
                w_cmd_z = '0;
            end
            MODE_HOLD: begin
                w_cmd_x = w_held[0];
                w_cmd_y = w_held[1];
                w_cmd_z = w_held[2];
            end
            default: begin
                w_cmd_x = r_tgt[0];
                w_cmd_y = r_tgt[1];
                w_cmd_z = r_tgt[2];
            end
        endcase
    end

    // gravity on z, saturated; an all-zero result falls back to gravity alone
    assign w_grav  = $signed(SUM_W'(w_cfg.gravity));
    assign w_zsum  = SUM_W'(w_cmd_z) + w_grav;
    assign w_zsat  = ((&w_zsum[SUM_W-1:DW-1]) || !(|w_zsum[SUM_W-1:DW-1])) ?
                     w_zsum[DW-1:0] : (w_zsum[SUM_W-1] ? D_MIN : D_MAX);
    assign w_gsat  = (!(|w_grav[SUM_W-1:DW-1])) ? w_grav[DW-1:0] : D_MAX;
    assign w_z_out = (w_cmd_x == '0 && w_cmd_y == '0 && w_zsat == '0) ? w_gsat : w_zsat;

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_acc_x     <= w_cmd_x;
            r_acc_y     <= w_cmd_y;
            r_acc_z     <= w_z_out;
            r_out_fresh <= r_fresh;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_acc_x     = r_acc_x;
    assign o_acc_y     = r_acc_y;
    assign o_acc_z     = r_acc_z;
    assign o_fresh     = r_out_fresh;

`ifndef SYNTHESIS
    // loop completion only while waiting on it
    a_done_in_loop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sts.done |-> r_state == TS_LOOP)
        else $error("loop done outside loop wait");

    // loop is never busy while a new item can be taken
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == TS_IDLE |-> !w_sts.busy)
        else $error("loop busy while top idle");

    // an even hold tick goes to the loop
    a_fresh_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_mode == MODE_HOLD && !r_phase)
            |=> r_state == TS_LOOP)
        else $error("fresh hold item did not start the loop");
`endif

endmodule

`default_nettype wire

@@ tb/tb_cascaded_position_velocity_pi_top.sv @@
// self-checking testbench for the cascaded position/velocity pi controller
// drives control ticks and register writes, predicts each acceleration command in-line
// depends on cpvpi_pkg and cascaded_position_velocity_pi_top
module tb_cascaded_position_velocity_pi_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cpvpi_pkg::*;

    localparam int DW = 32;
    localparam int FW = 16;
    localparam longint ONE_Q = 64'sd1 << FW;
    localparam longint DT_Q = ((64'sd1 << FW) * 2 + 50) / 100;
    localparam longint DMAX = 64'sd2147483647;
    localparam longint DMIN = -64'sd2147483648;
    localparam longint P_LIM = 64'sd1 << 50;
    localparam logic [DW-1:0] V_MAX = 32'h7fff_ffff;
    localparam logic [DW-1:0] V_MIN = 32'h8000_0000;
    localparam logic [MODE_W-1:0] MODE_UNDEF = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int STALL_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 120;
    localparam int PHASE_ITEMS = 160;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [DW-1:0] tx, ty, tz;
        logic [DW-1:0] px, py, pz;
        logic [DW-1:0] vx, vy, vz;
    } t_tick;

    typedef struct packed {
        logic [DW-1:0] ax, ay, az;
        logic fresh;
    } t_accel;

    typedef struct {
        t_tick it;
        bit lit;
        t_accel res;
    } t_row;

    // dut ports
    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    logic [MODE_W-1:0] i_mode;
    logic signed [DW-1:0] i_target_x, i_target_y, i_target_z;
    logic signed [DW-1:0] i_meas_pos_x, i_meas_pos_y, i_meas_pos_z;
    logic signed [DW-1:0] i_meas_vel_x, i_meas_vel_y, i_meas_vel_z;
    logic o_out_valid;
    logic i_out_ready;
    logic signed [DW-1:0] o_acc_x, o_acc_y, o_acc_z;
    logic o_fresh;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // shadow controller state and registers
    longint integ_q[3];
    longint held_q[3];
    bit tick_odd;
    logic [GAIN_W-1:0] g_pos_h, g_pos_v, g_kp_h, g_ki_h, g_kp_v, g_ki_v;
    logic [GRAV_W-1:0] g_grav;

    t_accel accel_due[$];
    t_row dir_rows[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int n_items = 0;
    int n_results = 0;
    int n_err = 0;
    int n_shown = 0;
    int n_settings = 1;
    int n_fresh = 0;
    int n_held = 0;
    int n_ff = 0;
    int n_rst = 0;
    int stall_cnt = 0;

    cascaded_position_velocity_pi_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_mode       (i_mode),
        .i_target_x   (i_target_x),
        .i_target_y   (i_target_y),
        .i_target_z   (i_target_z),
        .i_meas_pos_x (i_meas_pos_x),
        .i_meas_pos_y (i_meas_pos_y),
        .i_meas_pos_z (i_meas_pos_z),
        .i_meas_vel_x (i_meas_vel_x),
        .i_meas_vel_y (i_meas_vel_y),
        .i_meas_vel_z (i_meas_vel_z),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_acc_x      (o_acc_x),
        .o_acc_y      (o_acc_y),
        .o_acc_z      (o_acc_z),
        .o_fresh      (o_fresh),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // fixed-point helpers
    function automatic longint sat_data(longint x);
        if (x > DMAX) return DMAX;
        if (x < DMIN) return DMIN;
        return x;
    endfunction

    function automatic longint clip(longint x, longint lim);
        if (x > lim) return lim;
        if (x < -lim) return -lim;
        return x;
    endfunction

    // round half up, then floor
    function automatic longint rnd_shr(longint x, int k);
        return (x + (64'sd1 << (k - 1))) >>> k;
    endfunction

    // position p loop feeding velocity pi loop, one axis
    function automatic longint pi_axis(int a, longint tgt, longint pos, longint vel,
                                       longint pg, longint kp, longint ki);
        longint perr, vdes, verr, vi, acc_i, p;
        perr = sat_data(tgt - pos);
        vdes = sat_data(rnd_shr(pg * perr, GAIN_FRAC));
        verr = sat_data(vdes - vel);
        vi = clip(verr, ONE_Q * 128);
        acc_i = clip(integ_q[a] + rnd_shr(vi * DT_Q, FW), ONE_Q);
        integ_q[a] = acc_i;
        p = clip(kp * verr, P_LIM);
        return clip(rnd_shr(p + ki * acc_i, GAIN_FRAC), 2 * ONE_Q);
    endfunction

    // acceleration command for one tick, advancing the shadow state
    function automatic t_accel predict_accel(t_tick t);
        longint tgt[3], pos[3], vel[3], cmd[3];
        t_accel r;
        int a;
        tgt[0] = $signed(t.tx); tgt[1] = $signed(t.ty); tgt[2] = $signed(t.tz);
        pos[0] = $signed(t.px); pos[1] = $signed(t.py); pos[2] = $signed(t.pz);
        vel[0] = $signed(t.vx); vel[1] = $signed(t.vy); vel[2] = $signed(t.vz);
        r.fresh = 1'b0;
        case (t.mode)
            MODE_RESET: begin
                for (a = 0; a < AXES; a++) begin
                    integ_q[a] = 0;
                    cmd[a] = 0;
                end
                n_rst++;
            end
            MODE_HOLD: begin
                if (!tick_odd) begin
                    held_q[0] = pi_axis(0, tgt[0], pos[0], vel[0], g_pos_h, g_kp_h, g_ki_h);
                    held_q[1] = pi_axis(1, tgt[1], pos[1], vel[1], g_pos_h, g_kp_h, g_ki_h);
                    held_q[2] = pi_axis(2, tgt[2], pos[2], vel[2], g_pos_v, g_kp_v, g_ki_v);
                    r.fresh = 1'b1;
                    n_fresh++;
                end else begin
                    n_held++;
                end
                cmd = held_q;
            end
            default: begin
                // feedforward, undefined mode too
                for (a = 0; a < AXES; a++) begin
                    integ_q[a] = 0;
                    cmd[a] = tgt[a];
                end
                n_ff++;
            end
        endcase
        tick_odd = ~tick_odd;
        cmd[2] = sat_data(cmd[2] + longint'(g_grav));
        // an all-zero command still carries gravity
        if (cmd[0] == 0 && cmd[1] == 0 && cmd[2] == 0)
            cmd[2] = sat_data(longint'(g_grav));
        r.ax = DW'(cmd[0]);
        r.ay = DW'(cmd[1]);
        r.az = DW'(cmd[2]);
        return r;
    endfunction

    // stimulus builders
    function automatic t_tick mk_tick(logic [MODE_W-1:0] m,
                                      logic [DW-1:0] tx, logic [DW-1:0] ty, logic [DW-1:0] tz,
                                      logic [DW-1:0] px, logic [DW-1:0] py, logic [DW-1:0] pz,
                                      logic [DW-1:0] vx, logic [DW-1:0] vy, logic [DW-1:0] vz);
        t_tick t;
        t = '{m, tx, ty, tz, px, py, pz, vx, vy, vz};
        return t;
    endfunction

    function automatic t_accel mk_accel(logic [DW-1:0] x, logic [DW-1:0] y,
                                        logic [DW-1:0] z, logic f);
        t_accel r;
        r = '{x, y, z, f};
        return r;
    endfunction

    function automatic void add_row(t_tick t, bit lit, t_accel res);
        t_row row;
        row.it = t;
        row.lit = lit;
        row.res = res;
        dir_rows.push_back(row);
    endfunction

    function automatic logic [DW-1:0] near(int unsigned span);
        return DW'(int'($urandom_range(2 * span)) - int'(span));
    endfunction

    function automatic logic [DW-1:0] extreme_val();
        case ($urandom_range(4))
            0: return V_MAX;
            1: return V_MIN;
            2: return '0;
            3: return '1;
            default: return 32'd1;
        endcase
    endfunction

    function automatic logic [DW-1:0] any_val();
        int unsigned r;
        r = $urandom_range(9);
        if (r < 6) return $urandom();
        if (r < 8) return near(1 << 18);
        return extreme_val();
    endfunction

    function automatic t_tick noise_tick();
        t_tick t;
        t.mode = MODE_W'($urandom_range(3));
        t.tx = any_val(); t.ty = any_val(); t.tz = any_val();
        t.px = any_val(); t.py = any_val(); t.pz = any_val();
        t.vx = any_val(); t.vy = any_val(); t.vz = any_val();
        return t;
    endfunction

    // present one tick, entered and left at a falling edge
    task automatic send_tick(t_tick t, bit lit, t_accel lit_res);
        t_accel p;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode <= t.mode;
        i_target_x <= t.tx;
        i_target_y <= t.ty;
        i_target_z <= t.tz;
        i_meas_pos_x <= t.px;
        i_meas_pos_y <= t.py;
        i_meas_pos_z <= t.pz;
        i_meas_vel_x <= t.vx;
        i_meas_vel_y <= t.vy;
        i_meas_vel_z <= t.vz;
        do @(posedge i_clk); while (!o_in_ready);
        p = predict_accel(t);
        accel_due.push_back(lit ? lit_res : p);
        n_items++;
        @(negedge i_clk);
    endtask

    // stop sending until every expected command has come out
    task automatic wait_drain();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (accel_due.size() != 0);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_POS_GAIN_H: g_pos_h = val[GAIN_W-1:0];
            REG_POS_GAIN_V: g_pos_v = val[GAIN_W-1:0];
            REG_VEL_KP_H:   g_kp_h = val[GAIN_W-1:0];
            REG_VEL_KI_H:   g_ki_h = val[GAIN_W-1:0];
            REG_VEL_KP_V:   g_kp_v = val[GAIN_W-1:0];
            REG_VEL_KI_V:   g_ki_v = val[GAIN_W-1:0];
            REG_GRAVITY:    g_grav = val[GRAV_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // full register set, only called with the block idle
    task automatic load_gains(int unsigned pgh, int unsigned pgv, int unsigned kph,
                              int unsigned kih, int unsigned kpv, int unsigned kiv,
                              int unsigned grav, bit poke_unused);
        write_reg(REG_POS_GAIN_H, pgh);
        write_reg(REG_POS_GAIN_V, pgv);
        write_reg(REG_VEL_KP_H, kph);
        write_reg(REG_VEL_KI_H, kih);
        write_reg(REG_VEL_KP_V, kpv);
        write_reg(REG_VEL_KI_V, kiv);
        write_reg(REG_GRAVITY, grav);
        if (poke_unused)
            write_reg(REG_UNUSED, $urandom());
        i_cfg_valid <= 1'b0;
        n_settings++;
    endtask

    // mostly hold bursts with a steady offset so the integrators charge, plus noise
    task automatic run_random(int n);
        int sent, len, k, a;
        int unsigned span;
        logic [DW-1:0] base[3], off[3], vb[3];
        t_tick t;
        sent = 0;
        while (sent < n) begin
            if ($urandom_range(99) < 70) begin
                len = $urandom_range(60, 8);
                span = ($urandom_range(3) == 0) ? (1 << 22) : (1 << 17);
                for (a = 0; a < AXES; a++) begin
                    base[a] = near(1 << 20);
                    off[a] = near(span);
                    vb[a] = near(span / 2);
                end
                for (k = 0; k < len && sent < n; k++) begin
                    if ($urandom_range(9) == 0) begin
                        t = noise_tick();
                    end else begin
                        t.tx = base[0] + near(1 << 12);
                        t.ty = base[1] + near(1 << 12);
                        t.tz = base[2] + near(1 << 12);
                        t.px = base[0] + off[0] + near(1 << 12);
                        t.py = base[1] + off[1] + near(1 << 12);
                        t.pz = base[2] + off[2] + near(1 << 12);
                        t.vx = vb[0] + near(1 << 12);
                        t.vy = vb[1] + near(1 << 12);
                        t.vz = vb[2] + near(1 << 12);
                    end
                    t.mode = MODE_HOLD;
                    send_tick(t, 1'b0, '0);
                    sent++;
                end
            end else begin
                len = $urandom_range(3, 1);
                for (k = 0; k < len && sent < n; k++) begin
                    send_tick(noise_tick(), 1'b0, '0);
                    sent++;
                end
            end
            if ($urandom_range(99) < 4)
                wait_drain();
        end
    endtask

    // receiver back-pressure
    always @(negedge i_clk)
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);

    // result checker and watchdog
    always @(posedge i_clk) begin
        t_accel got, want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                got = '{o_acc_x, o_acc_y, o_acc_z, o_fresh};
                n_results++;
                if (accel_due.size() == 0) begin
                    n_err++;
                    if (n_shown < 10)
                        $display("unexpected command (%0d, %0d, %0d, fresh %0b)",
                                 $signed(got.ax), $signed(got.ay), $signed(got.az), got.fresh);
                    n_shown++;
                end else begin
                    want = accel_due.pop_front();
                    if (got.ax !== want.ax || got.ay !== want.ay ||
                        got.az !== want.az || got.fresh !== want.fresh) begin
                        n_err++;
                        if (n_shown < 10)
                            $display("command %0d: want (%0d, %0d, %0d, fresh %0b) got (%0d, %0d, %0d, fresh %0b)",
                                     n_results, $signed(want.ax), $signed(want.ay),
                                     $signed(want.az), want.fresh, $signed(got.ax),
                                     $signed(got.ay), $signed(got.az), got.fresh);
                        n_shown++;
                    end
                end
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                stall_cnt = 0;
            end else begin
                stall_cnt++;
                if (stall_cnt >= STALL_LIMIT) begin
                    $display("watchdog: nothing moved for %0d cycles", STALL_LIMIT);
                    $display("cascaded_position_velocity_pi_top regression: fail");
                    $finish;
                end
            end
        end
    end

    // main sequence
    initial begin
        int r;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_out_ready = 1'b1;
        i_mode = MODE_RESET;
        {i_target_x, i_target_y, i_target_z} = '0;
        {i_meas_pos_x, i_meas_pos_y, i_meas_pos_z} = '0;
        {i_meas_vel_x, i_meas_vel_y, i_meas_vel_z} = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_POS_GAIN_H;
        i_cfg_data = '0;
        tick_odd = 1'b0;
        integ_q = '{0, 0, 0};
        held_q = '{0, 0, 0};
        g_pos_h = RST_POS_GAIN_H;
        g_pos_v = RST_POS_GAIN_V;
        g_kp_h = RST_VEL_KP_H;
        g_ki_h = RST_VEL_KI_H;
        g_kp_v = RST_VEL_KP_V;
        g_ki_v = RST_VEL_KI_V;
        g_grav = RST_GRAVITY;

        // directed ticks at reset register values, tick phase counted from zero
        add_row(mk_tick(MODE_RESET, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                mk_accel(0, 0, 32'd642908, 1'b0));
        add_row(mk_tick(MODE_FF, V_MAX, V_MIN, V_MAX, 0, 0, 0, 0, 0, 0), 1'b1,
                mk_accel(V_MAX, V_MIN, V_MAX, 1'b0));
        // saturated errors push integrators and output to their positive, then negative limits
        add_row(mk_tick(MODE_HOLD, V_MAX, V_MAX, V_MAX, V_MIN, V_MIN, V_MIN,
                        V_MIN, V_MIN, V_MIN), 1'b1,
                mk_accel(32'd131072, 32'd131072, 32'd773980, 1'b1));
        add_row(mk_tick(MODE_HOLD, V_MAX, V_MAX, V_MAX, V_MIN, V_MIN, V_MIN,
                        V_MIN, V_MIN, V_MIN), 1'b1,
                mk_accel(32'd131072, 32'd131072, 32'd773980, 1'b0));
        add_row(mk_tick(MODE_HOLD, V_MIN, V_MIN, V_MIN, V_MAX, V_MAX, V_MAX,
                        V_MAX, V_MAX, V_MAX), 1'b1,
                mk_accel(-32'sd131072, -32'sd131072, 32'd511836, 1'b1));
        add_row(mk_tick(MODE_HOLD, 32'h1234_5678, 32'h0bad_f00d, 32'h7654_3210,
                        32'h0f0f_0f0f, 32'hf0f0_f0f0, 32'h0000_ffff,
                        32'hffff_0000, 32'h0001_0000, 32'hfffe_0000), 1'b0, '0);
        // feedforward that cancels gravity leaves an all-zero vector
        add_row(mk_tick(MODE_FF, 0, 0, -32'sd642908, 0, 0, 0, 0, 0, 0), 1'b1,
                mk_accel(0, 0, 32'd642908, 1'b0));
        add_row(mk_tick(MODE_UNDEF, 32'd1, '1, 32'd5, 32'h5555_5555, 32'haaaa_aaaa, V_MAX,
                        V_MIN, '1, 32'd7), 1'b0, '0);
        add_row(mk_tick(MODE_RESET, 32'hdead_beef, V_MAX, V_MIN, '1, 32'h1357_9bdf,
                        32'h2468_ace0, V_MIN, V_MAX, '1), 1'b1,
                mk_accel(0, 0, 32'd642908, 1'b0));
        add_row(mk_tick(MODE_HOLD, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
        add_row(mk_tick(MODE_HOLD, 32'd65536, -32'sd32768, 32'd131072, 0, 0, 0,
                        32'd1000, -32'sd2000, 32'd300), 1'b0, '0);
        add_row(mk_tick(MODE_HOLD, 32'd65536, -32'sd32768, 32'd131072, 0, 0, 0,
                        32'd1000, -32'sd2000, 32'd300), 1'b0, '0);
        add_row(mk_tick(MODE_HOLD, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
        add_row(mk_tick(MODE_HOLD, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
        add_row(mk_tick(MODE_FF, V_MIN, V_MAX, V_MIN, 0, 0, 0, 0, 0, 0), 1'b0, '0);
        add_row(mk_tick(MODE_HOLD, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555,
                        32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa,
                        32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555), 1'b0, '0);
        add_row(mk_tick(MODE_HOLD, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa,
                        32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555,
                        32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa), 1'b0, '0);
        add_row(mk_tick(MODE_RESET, '1, '1, '1, '1, '1, '1, '1, '1, '1), 1'b0, '0);
        add_row(mk_tick(MODE_FF, '1, '1, '1, '1, '1, '1, '1, '1, '1), 1'b0, '0);

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // phase 0: directed table then random, no idling, reset values
        for (r = 0; r < dir_rows.size(); r++)
            send_tick(dir_rows[r].it, dir_rows[r].lit, dir_rows[r].res);
        run_random(PHASE_ITEMS);
        wait_drain();

        // phase 1: largest gains, gravity at the top of the tested range, sender mostly idle
        send_idle_pct = 79;
        recv_stall_pct = 0;
        load_gains(65535, 65535, 65535, 65535, 65535, 65535, 1310720, 1'b0);
        run_random(PHASE_ITEMS);
        wait_drain();

        // phase 2: all gains and gravity zero, receiver mostly stalling
        send_idle_pct = 0;
        recv_stall_pct = 79;
        load_gains(0, 0, 0, 0, 0, 0, 0, 1'b0);
        run_random(PHASE_ITEMS);
        wait_drain();

        // phase 3: random settings plus a write to the unused index, both sides idling
        send_idle_pct = 22;
        recv_stall_pct = 22;
        load_gains($urandom_range(65535), $urandom_range(65535), $urandom_range(65535),
                   $urandom_range(65535), $urandom_range(65535), $urandom_range(65535),
                   $urandom_range(1310720), 1'b1);
        run_random(PHASE_ITEMS);

        // let the block settle and catch any stray output
        wait_drain();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        n_err += accel_due.size();

        $display("run: %0d ticks, %0d commands checked, %0d register settings, %0d errors",
                 n_items, n_results, n_settings, n_err);
        $display("run: %0d recomputed hold, %0d held hold, %0d feedforward, %0d reset ticks",
                 n_fresh, n_held, n_ff, n_rst);
        if (n_err == 0) begin
            $display("cascaded_position_velocity_pi_top regression: pass");
        end else begin
            $display("cascaded_position_velocity_pi_top regression: fail");
        end
        $finish;
    end

endmodule
